/* rtl/mfsk_tone_synthesizer_assert.svh */
// Assertion helpers for the MFSK tone synthesizer.
// Each macro takes a label, the clock, the active-low reset and the two sides
// of the implication.
`ifndef MFSK_TONE_SYNTHESIZER_ASSERT_SVH
`define MFSK_TONE_SYNTHESIZER_ASSERT_SVH

`ifndef SYNTHESIS

`define MFSK_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mfsk assertion failed");

`define MFSK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mfsk assertion failed");

`else

`define MFSK_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`define MFSK_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/mfsk_pkg.sv */
package mfsk_pkg;

    localparam int SYMBOL_COUNT    = 85;
    localparam int SINE_TABLE_BITS = 10;

    localparam int SYM_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int WORD_W     = 32;
    localparam int SPS_W      = 18;
    localparam int TOTAL_W    = 24;
    localparam int SPAN_W     = SPS_W + 7;
    localparam int RAMP_W     = 9;
    localparam int RSTEP_W    = 17;
    localparam int TONE_W     = 7;
    localparam int TONE_IDX_W = 7;
    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int SAMPLE_MAX = 32767;

    typedef logic [WORD_W-1:0]         word_t;
    typedef logic [2*WORD_W-1:0]       prod_t;
    typedef logic [SPS_W-1:0]          sps_t;
    typedef logic [TOTAL_W-1:0]        pos_t;
    typedef logic [SPAN_W-1:0]         span_t;
    typedef logic [SYM_W-1:0]          sym_t;
    typedef logic [TONE_W-1:0]         tone_t;
    typedef logic [TONE_IDX_W:0]       tone_idx_ext_t;
    typedef logic [RAMP_W-1:0]         ramp_t;
    typedef logic [RSTEP_W-1:0]        rstep_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic [APB_DATA_W-1:0]     apb_data_t;

    // Quarter-wave sine polynomial coefficients, Q30
    localparam word_t SC1     = 32'd1686629713;
    localparam word_t SC3     = 32'd693598668;
    localparam word_t SC5     = 32'd85569278;
    localparam word_t SC7     = 32'd5026990;
    localparam word_t SC9     = 32'd172272;
    localparam word_t ONE_Q30 = 32'h4000_0000;
    localparam word_t AMP_Q15 = 32'd19005;
    localparam angle_t COS_OFFSET = 16'h4000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_BASE_STEP = 3'd0,
        REG_TONE_STEP = 3'd1,
        REG_SPS       = 3'd2,
        REG_TOTAL     = 3'd3,
        REG_RAMP      = 3'd4,
        REG_RAMP_STEP = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACTIVE,
        ST_CHECK,
        ST_WAIT,
        ST_PHASE,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_SIN_E,
        ST_SIN_F,
        ST_SIN_G,
        ST_RAMP,
        ST_RAMP_ANG,
        ST_MAG,
        ST_AMP,
        ST_RND,
        ST_OUT
    } state_t;

    typedef struct packed {
        word_t  base_phase_step;
        word_t  tone_phase_step;
        sps_t   samples_per_symbol;
        pos_t   total_samples;
        ramp_t  ramp_samples;
        rstep_t ramp_phase_step;
    } cfg_t;

endpackage

/* rtl/mfsk_cfg.sv */
module mfsk_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfsk_pkg::APB_ADDR_W-1:0]     paddr,
    input  mfsk_pkg::apb_data_t                 pwdata,
    output mfsk_pkg::apb_data_t                 prdata,
    output logic                                pready,
    output mfsk_pkg::cfg_t                      cfg
);

    mfsk_pkg::word_t  base_step_reg;
    mfsk_pkg::word_t  tone_step_reg;
    mfsk_pkg::sps_t   sps_reg;
    mfsk_pkg::pos_t   total_reg;
    mfsk_pkg::ramp_t  ramp_reg;
    mfsk_pkg::rstep_t ramp_step_reg;

    mfsk_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign reg_idx = mfsk_pkg::reg_idx_t'(paddr[mfsk_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_step_reg <= '0;
            tone_step_reg <= '0;
            sps_reg       <= mfsk_pkg::sps_t'(28800);
            total_reg     <= mfsk_pkg::pos_t'(2865600);
            ramp_reg      <= mfsk_pkg::ramp_t'(240);
            ramp_step_reg <= mfsk_pkg::rstep_t'(273);
        end else if (wr_en) begin
            case (reg_idx)
                mfsk_pkg::REG_BASE_STEP: base_step_reg <= pwdata;
                mfsk_pkg::REG_TONE_STEP: tone_step_reg <= pwdata;
                mfsk_pkg::REG_SPS:       sps_reg       <= pwdata[mfsk_pkg::SPS_W-1:0];
                mfsk_pkg::REG_TOTAL:     total_reg     <= pwdata[mfsk_pkg::TOTAL_W-1:0];
                mfsk_pkg::REG_RAMP:      ramp_reg      <= pwdata[mfsk_pkg::RAMP_W-1:0];
                mfsk_pkg::REG_RAMP_STEP: ramp_step_reg <= pwdata[mfsk_pkg::RSTEP_W-1:0];
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mfsk_pkg::REG_BASE_STEP: prdata = base_step_reg;
            mfsk_pkg::REG_TONE_STEP: prdata = tone_step_reg;
            mfsk_pkg::REG_SPS:       prdata = mfsk_pkg::apb_data_t'(sps_reg);
            mfsk_pkg::REG_TOTAL:     prdata = mfsk_pkg::apb_data_t'(total_reg);
            mfsk_pkg::REG_RAMP:      prdata = mfsk_pkg::apb_data_t'(ramp_reg);
            mfsk_pkg::REG_RAMP_STEP: prdata = mfsk_pkg::apb_data_t'(ramp_step_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.base_phase_step    = base_step_reg;
    assign cfg.tone_phase_step    = tone_step_reg;
    assign cfg.samples_per_symbol = sps_reg;
    assign cfg.total_samples      = total_reg;
    assign cfg.ramp_samples       = ramp_reg;
    assign cfg.ramp_phase_step    = ramp_step_reg;

endmodule

/* rtl/mfsk_mul.sv */
module mfsk_mul (
    input  logic            aclk,
    input  mfsk_pkg::word_t mul_a,
    input  mfsk_pkg::word_t mul_b,
    output mfsk_pkg::prod_t mul_p
);

    mfsk_pkg::word_t a_reg;
    mfsk_pkg::word_t b_reg;
    mfsk_pkg::prod_t p_reg;

    // Operands registered, then the product registered
    always_ff @(posedge aclk) begin
        a_reg <= mul_a;
        b_reg <= mul_b;
        p_reg <= mfsk_pkg::prod_t'(a_reg) * mfsk_pkg::prod_t'(b_reg);
    end

    assign mul_p = p_reg;

endmodule

/* rtl/mfsk_core.sv */
module mfsk_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mfsk_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mfsk_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic [mfsk_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output mfsk_pkg::sample_t               m_tdata,
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast,
    output mfsk_pkg::word_t                 mul_a,
    output mfsk_pkg::word_t                 mul_b,
    input  mfsk_pkg::prod_t                 mul_p
);

    `include "mfsk_tone_synthesizer_assert.svh"

    // control state
    mfsk_pkg::state_t  state_reg, state_next;
    mfsk_pkg::state_t  ret_reg, ret_next;
    mfsk_pkg::pos_t    pos_reg, pos_next;
    mfsk_pkg::sps_t    sym_cnt_reg, sym_cnt_next;
    mfsk_pkg::sym_t    sym_reg, sym_next;
    mfsk_pkg::word_t   phase_reg, phase_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // working registers
    logic              ramp_pass_reg, ramp_pass_next;
    mfsk_pkg::word_t   phase_sum_reg, phase_sum_next;
    mfsk_pkg::span_t   span_reg;
    mfsk_pkg::pos_t    active_reg, active_next;
    mfsk_pkg::pos_t    edge_dist_reg, edge_dist_next;
    mfsk_pkg::angle_t  sin_angle_reg, sin_angle_next;
    mfsk_pkg::word_t   x_reg, x_next;
    mfsk_pkg::word_t   x2_reg, x2_next;
    mfsk_pkg::word_t   mag_reg, mag_next;
    logic              neg_reg, neg_next;
    mfsk_pkg::word_t   gain_reg, gain_next;
    mfsk_pkg::sample_t res_sample_reg, res_sample_next;
    logic              res_done_reg, res_done_next;
    logic              res_last_reg, res_last_next;
    mfsk_pkg::sample_t m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    mfsk_pkg::tone_t   tone_mem [mfsk_pkg::SYMBOL_COUNT];
    mfsk_pkg::tone_t   tone_rd_reg;
    logic              tone_we;

    // datapath helpers
    logic                            in_accept;
    mfsk_pkg::cmd_t                  in_cmd;
    logic [mfsk_pkg::TONE_IDX_W-1:0] in_idx;
    mfsk_pkg::tone_t                 in_tone;
    mfsk_pkg::word_t                 prod_hi;
    logic [14:0]                     fold_r;
    mfsk_pkg::pos_t                  pos_inc;
    mfsk_pkg::pos_t                  from_end;
    mfsk_pkg::pos_t                  edge_min;
    mfsk_pkg::sps_t                  cnt_inc;
    mfsk_pkg::word_t                 phase_new;
    mfsk_pkg::pos_t                  active_min;
    logic                            ramp_unity;
    logic [32:0]                     cos_v;
    mfsk_pkg::word_t                 cos_half;
    mfsk_pkg::word_t                 gain_cos;
    logic [47:0]                     rnd;
    logic [17:0]                     amp_v;
    mfsk_pkg::sample_t               amp_clip;

    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = mfsk_pkg::cmd_t'(s_tuser);
    assign in_idx    = s_tdata[mfsk_pkg::TONE_IDX_W-1:0];
    assign in_tone   = s_tdata[mfsk_pkg::TONE_IDX_W +: mfsk_pkg::TONE_W];

    assign prod_hi   = mul_p[61:30];
    // fold the angle into the first quadrant
    assign fold_r    = sin_angle_reg[14] ? (15'd16384 - {1'b0, sin_angle_reg[13:0]})
                                         : {1'b0, sin_angle_reg[13:0]};
    assign pos_inc   = pos_reg + 1'b1;
    assign from_end  = active_reg - pos_reg;
    assign edge_min  = (pos_inc < from_end) ? pos_inc : from_end;
    assign cnt_inc   = sym_cnt_reg + 1'b1;
    assign phase_new = phase_sum_reg + mul_p[mfsk_pkg::WORD_W-1:0];
    assign active_min = (span_reg > mfsk_pkg::span_t'(cfg.total_samples))
                      ? cfg.total_samples : span_reg[mfsk_pkg::TOTAL_W-1:0];
    assign ramp_unity = (cfg.ramp_samples == '0) || (active_reg <= mfsk_pkg::pos_t'(1))
                     || (edge_dist_reg >= mfsk_pkg::pos_t'(cfg.ramp_samples));

    // raised-cosine gain from the cosine magnitude and sign
    always_comb begin
        if (sin_angle_reg[15]) begin
            cos_v = {1'b0, mfsk_pkg::ONE_Q30} + {1'b0, prod_hi};
        end else if (prod_hi > mfsk_pkg::ONE_Q30) begin
            cos_v = '0;
        end else begin
            cos_v = {1'b0, mfsk_pkg::ONE_Q30 - prod_hi};
        end
    end
    assign cos_half = cos_v[32:1];
    assign gain_cos = (cos_half > mfsk_pkg::ONE_Q30) ? mfsk_pkg::ONE_Q30 : cos_half;

    assign rnd      = mul_p[47:0] + (48'd1 << 29);
    assign amp_v    = rnd[47:30];
    assign amp_clip = (amp_v > 18'(mfsk_pkg::SAMPLE_MAX))
                    ? mfsk_pkg::sample_t'(mfsk_pkg::SAMPLE_MAX) : mfsk_pkg::sample_t'(amp_v[15:0]);

    assign s_tready = (state_reg == mfsk_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        pos_next        = pos_reg;
        sym_cnt_next    = sym_cnt_reg;
        sym_next        = sym_reg;
        phase_next      = phase_reg;
        m_tvalid_next   = m_tvalid_reg;
        ramp_pass_next  = ramp_pass_reg;
        phase_sum_next  = phase_sum_reg;
        active_next     = active_reg;
        edge_dist_next  = edge_dist_reg;
        sin_angle_next  = sin_angle_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        gain_next       = gain_reg;
        res_sample_next = res_sample_reg;
        res_done_next   = res_done_reg;
        res_last_next   = res_last_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        mul_a           = '0;
        mul_b           = '0;
        tone_we         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            mfsk_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (in_cmd)
                        mfsk_pkg::CMD_LOAD: begin
                            tone_we = ({1'b0, in_idx}
                                    < mfsk_pkg::tone_idx_ext_t'(mfsk_pkg::SYMBOL_COUNT));
                        end
                        mfsk_pkg::CMD_RESTART: begin
                            pos_next     = '0;
                            sym_cnt_next = '0;
                            sym_next     = '0;
                            phase_next   = '0;
                        end
                        mfsk_pkg::CMD_TICK: begin
                            state_next = mfsk_pkg::ST_ACTIVE;
                        end
                        default: begin
                            // unused command: drop the item
                        end
                    endcase
                end
            end
            mfsk_pkg::ST_ACTIVE: begin
                active_next    = active_min;
                phase_sum_next = phase_reg + cfg.base_phase_step;
                state_next     = mfsk_pkg::ST_CHECK;
            end
            mfsk_pkg::ST_CHECK: begin
                res_sample_next = '0;
                if (pos_reg >= cfg.total_samples) begin
                    // past the period: hold position, flag done
                    res_done_next = 1'b1;
                    res_last_next = 1'b0;
                    state_next    = mfsk_pkg::ST_OUT;
                end else begin
                    pos_next      = pos_inc;
                    res_done_next = (pos_inc == cfg.total_samples);
                    res_last_next = (pos_inc == cfg.total_samples);
                    if (pos_reg < active_reg) begin
                        edge_dist_next = edge_min;
                        if (cnt_inc >= cfg.samples_per_symbol) begin
                            sym_cnt_next = '0;
                            if (sym_reg != mfsk_pkg::sym_t'(mfsk_pkg::SYMBOL_COUNT - 1)) begin
                                sym_next = sym_reg + 1'b1;
                            end
                        end else begin
                            sym_cnt_next = cnt_inc;
                        end
                        mul_a      = cfg.tone_phase_step;
                        mul_b      = mfsk_pkg::word_t'(tone_rd_reg);
                        ret_next   = mfsk_pkg::ST_PHASE;
                        state_next = mfsk_pkg::ST_WAIT;
                    end else begin
                        state_next = mfsk_pkg::ST_OUT;
                    end
                end
            end
            mfsk_pkg::ST_WAIT: begin
                state_next = ret_reg;
            end
            mfsk_pkg::ST_PHASE: begin
                phase_next     = phase_new;
                sin_angle_next = {phase_new[mfsk_pkg::WORD_W-1 -: mfsk_pkg::SINE_TABLE_BITS],
                                  {(mfsk_pkg::ANGLE_W - mfsk_pkg::SINE_TABLE_BITS){1'b0}}};
                ramp_pass_next = 1'b0;
                state_next     = mfsk_pkg::ST_SIN_A;
            end
            mfsk_pkg::ST_SIN_A: begin
                x_next     = {1'b0, fold_r, 16'd0};
                mul_a      = {1'b0, fold_r, 16'd0};
                mul_b      = {1'b0, fold_r, 16'd0};
                ret_next   = mfsk_pkg::ST_SIN_B;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_B: begin
                x2_next    = prod_hi;
                mul_a      = mfsk_pkg::SC9;
                mul_b      = prod_hi;
                ret_next   = mfsk_pkg::ST_SIN_C;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_C: begin
                mul_a      = mfsk_pkg::SC7 - prod_hi;
                mul_b      = x2_reg;
                ret_next   = mfsk_pkg::ST_SIN_D;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_D: begin
                mul_a      = mfsk_pkg::SC5 - prod_hi;
                mul_b      = x2_reg;
                ret_next   = mfsk_pkg::ST_SIN_E;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_E: begin
                mul_a      = mfsk_pkg::SC3 - prod_hi;
                mul_b      = x2_reg;
                ret_next   = mfsk_pkg::ST_SIN_F;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_F: begin
                mul_a      = mfsk_pkg::SC1 - prod_hi;
                mul_b      = x_reg;
                ret_next   = mfsk_pkg::ST_SIN_G;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_SIN_G: begin
                if (ramp_pass_reg) begin
                    gain_next  = gain_cos;
                    state_next = mfsk_pkg::ST_MAG;
                end else begin
                    mag_next   = prod_hi;
                    neg_next   = sin_angle_reg[15];
                    state_next = mfsk_pkg::ST_RAMP;
                end
            end
            mfsk_pkg::ST_RAMP: begin
                if (ramp_unity) begin
                    gain_next  = mfsk_pkg::ONE_Q30;
                    state_next = mfsk_pkg::ST_MAG;
                end else begin
                    mul_a      = mfsk_pkg::word_t'(cfg.ramp_phase_step);
                    mul_b      = mfsk_pkg::word_t'(edge_dist_reg[mfsk_pkg::RAMP_W-1:0]);
                    ret_next   = mfsk_pkg::ST_RAMP_ANG;
                    state_next = mfsk_pkg::ST_WAIT;
                end
            end
            mfsk_pkg::ST_RAMP_ANG: begin
                // cosine as sine a quarter turn on
                sin_angle_next = mul_p[16:1] + mfsk_pkg::COS_OFFSET;
                ramp_pass_next = 1'b1;
                state_next     = mfsk_pkg::ST_SIN_A;
            end
            mfsk_pkg::ST_MAG: begin
                mul_a      = mag_reg;
                mul_b      = gain_reg;
                ret_next   = mfsk_pkg::ST_AMP;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_AMP: begin
                mul_a      = prod_hi;
                mul_b      = mfsk_pkg::AMP_Q15;
                ret_next   = mfsk_pkg::ST_RND;
                state_next = mfsk_pkg::ST_WAIT;
            end
            mfsk_pkg::ST_RND: begin
                res_sample_next = neg_reg ? -amp_clip : amp_clip;
                state_next      = mfsk_pkg::ST_OUT;
            end
            mfsk_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_sample_reg;
                    m_tuser_next  = res_done_reg;
                    m_tlast_next  = res_last_reg;
                    state_next    = mfsk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfsk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mfsk_pkg::ST_IDLE;
            ret_reg      <= mfsk_pkg::ST_IDLE;
            pos_reg      <= '0;
            sym_cnt_reg  <= '0;
            sym_reg      <= '0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            pos_reg      <= pos_next;
            sym_cnt_reg  <= sym_cnt_next;
            sym_reg      <= sym_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ramp_pass_reg  <= ramp_pass_next;
        phase_sum_reg  <= phase_sum_next;
        span_reg       <= mfsk_pkg::span_t'(cfg.samples_per_symbol)
                        * mfsk_pkg::span_t'(mfsk_pkg::SYMBOL_COUNT);
        active_reg     <= active_next;
        edge_dist_reg  <= edge_dist_next;
        sin_angle_reg  <= sin_angle_next;
        x_reg          <= x_next;
        x2_reg         <= x2_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        gain_reg       <= gain_next;
        res_sample_reg <= res_sample_next;
        res_done_reg   <= res_done_next;
        res_last_reg   <= res_last_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (tone_we) begin
            tone_mem[in_idx[mfsk_pkg::SYM_W-1:0]] <= in_tone;
        end
        tone_rd_reg <= tone_mem[sym_reg];
    end

    `MFSK_ASSERT_IMPLY(a_pos_step, aclk, aresetn, !$stable(pos_reg),
        (pos_reg == $past(pos_reg) + 1'b1) || (pos_reg == '0))
    `MFSK_ASSERT_IMPLY(a_sym_step, aclk, aresetn, !$stable(sym_reg),
        (sym_reg == $past(sym_reg) + 1'b1) || (sym_reg == '0))
    `MFSK_ASSERT_NEXT(a_tick_starts, aclk, aresetn,
        in_accept && (in_cmd == mfsk_pkg::CMD_TICK), state_reg == mfsk_pkg::ST_ACTIVE)
    `MFSK_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        (state_reg == mfsk_pkg::ST_OUT) && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && (state_reg == mfsk_pkg::ST_IDLE))
    `MFSK_ASSERT_IMPLY(a_gain_range, aclk, aresetn, state_reg == mfsk_pkg::ST_MAG,
        gain_reg <= mfsk_pkg::ONE_Q30)

endmodule

/* rtl/mfsk_tone_synthesizer.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: tone_index, tone_value; tuser: cmd
// m_        out  m_tvalid/m_tready  tdata: sample; tuser: done_res; tlast: last
// APB       in   psel/penable       six registers at byte address 4*i
//
// Load and restart items are handled in the idle state. A tick in the active span
// runs the sine polynomial on the single 32x32 multiplier once per sample, and again
// for the ramp cosine inside an edge ramp. A silent or past-the-period tick skips
// the multiplier.
// Reset is synchronous, active low; the tone table is not cleared.
// A finished item waits in the output register; the next item is taken meanwhile.
module mfsk_tone_synthesizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [6:0] tone_index, [13:7] tone_value
    input  logic [1:0]                      s_tuser,   // [1:0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic signed [15:0]              m_tdata,   // [15:0] sample
    output logic [0:0]                      m_tuser,   // [0] done_res
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfsk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    mfsk_pkg::cfg_t  cfg;
    mfsk_pkg::word_t mul_a;
    mfsk_pkg::word_t mul_b;
    mfsk_pkg::prod_t mul_p;

    mfsk_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfsk_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    mfsk_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

endmodule
